// ===== hw/rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes of the prefix access list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

    // operation codes
    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_DELETE = 2'd2,
        FN_APPLY  = 2'd3
    } t_func;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADLIST = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_UNDEF   = 3'd3;
    localparam logic [2:0] ST_NORULE  = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    localparam int QDEPTH = 2;

    // one stored rule, length already clamped, mask zero without wildcard
    typedef struct packed {
        logic [31:0] addr;
        logic        has_wild;
        logic [31:0] wild;
        logic        permit;
        logic        all;
        logic [5:0]  len;
        logic        exact;
        logic        refine;
    } t_rule;

    // classified command handed from front to back
    typedef struct packed {
        t_func      func;
        logic       bad;
        logic [7:0] list;
        t_rule      rule;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // leading-ones mask of a prefix length (0..32)
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        m = '0;
        if (len != 6'd0) begin
            m = 32'hFFFF_FFFF << (6'd32 - len);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/prefix_access_list_engine.sv =====
// ----------------------------------------------------------------------------
// prefix_access_list_engine
// Numbered IPv4 prefix access lists: add, remove, delete and first-match apply.
//
//   channel   dir   handshake              payload
//   command   in    i_valid / o_stall      i_func .. i_refine_flag
//   result    out   o_valid / i_stall      o_status, o_rule_count, o_permitted
//
// The back walks the rule memory one read a cycle on an add or an apply, over
// the whole list or up to the first matching rule; an apply to list zero does
// not walk. A remove moves each later rule down with a read and a write, and
// delete, a bad list and an undefined list do not walk. The result passes the
// front register, the queue and the back after the item is accepted. Reset is
// synchronous and empties every list. A front register and a two-deep queue
// keep taking items while the back walks, and the result register holds under
// output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_access_list_engine #(
    parameter int NUM_LISTS      = 16,
    parameter int RULES_PER_LIST = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_func,
    input  wire  [7:0]  i_list_num,
    input  wire         i_permit,
    input  wire         i_match_all,
    input  wire  [5:0]  i_prefix_len,
    input  wire  [31:0] i_prefix_addr,
    input  wire         i_has_wildcard,
    input  wire  [31:0] i_wildcard_mask,
    input  wire         i_exact_flag,
    input  wire         i_refine_flag,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_rule_count,
    output logic        o_permitted
);
    import pal_pkg::*;

    t_cmd        fe_cmd;
    t_cmd        q_cmd;
    t_qstat      q_st;
    logic        fe_push;
    logic        be_pop;
    logic [2:0]  r_inflight;

    pal_front #(.NUM_LISTS(NUM_LISTS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_func, .i_list_num, .i_permit, .i_match_all, .i_prefix_len,
        .i_prefix_addr, .i_has_wildcard, .i_wildcard_mask, .i_exact_flag,
        .i_refine_flag,
        .i_qstat(q_st), .o_push(fe_push), .o_cmd(fe_cmd)
    );

    pal_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(fe_push), .i_cmd(fe_cmd), .i_pop(be_pop),
        .o_cmd(q_cmd), .o_qstat(q_st)
    );

    pal_back #(.NUM_LISTS(NUM_LISTS), .RULES_PER_LIST(RULES_PER_LIST)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd(q_cmd), .i_qstat(q_st), .o_pop(be_pop),
        .o_valid, .i_stall, .o_status, .o_rule_count, .o_permitted
    );

    // count items inside the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'((i_valid && !o_stall) ? 1 : 0)
                                     - 3'((o_valid && !i_stall) ? 1 : 0);
        end
    end

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_inflight != 3'd0))
        else $error("result without an item inside");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd5)
        else $error("more items inside than storage");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        be_pop |-> !q_st.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/pal_front.sv =====
// ----------------------------------------------------------------------------
// pal_front
// Accepts items, clamps the length, builds the rule and flags a bad list.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_front #(
    parameter int NUM_LISTS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [1:0]          i_func,
    input  wire  [7:0]          i_list_num,
    input  wire                 i_permit,
    input  wire                 i_match_all,
    input  wire  [5:0]          i_prefix_len,
    input  wire  [31:0]         i_prefix_addr,
    input  wire                 i_has_wildcard,
    input  wire  [31:0]         i_wildcard_mask,
    input  wire                 i_exact_flag,
    input  wire                 i_refine_flag,
    input  pal_pkg::t_qstat     i_qstat,
    output logic                o_push,
    output pal_pkg::t_cmd       o_cmd
);
    import pal_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  accept;

    assign o_push  = r_valid && !i_qstat.full;
    assign o_stall = r_valid && i_qstat.full;
    assign accept  = i_valid && !o_stall;
    assign o_cmd   = r_cmd;

    // classify the incoming item
    always_comb begin
        n_cmd               = '0;
        n_cmd.func          = t_func'(i_func);
        n_cmd.bad           = (9'(i_list_num) >= 9'(NUM_LISTS));
        n_cmd.list          = i_list_num;
        n_cmd.rule.addr     = i_prefix_addr;
        n_cmd.rule.has_wild = i_has_wildcard;
        n_cmd.rule.wild     = i_has_wildcard ? i_wildcard_mask : 32'd0;
        n_cmd.rule.permit   = i_permit;
        n_cmd.rule.all      = i_match_all;
        n_cmd.rule.len      = (i_prefix_len > 6'd32) ? 6'd32 : i_prefix_len;
        n_cmd.rule.exact    = i_exact_flag;
        n_cmd.rule.refine   = i_refine_flag;
    end

    // hold one item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pal_queue.sv =====
// ----------------------------------------------------------------------------
// pal_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  pal_pkg::t_cmd     i_cmd,
    input  wire               i_pop,
    output pal_pkg::t_cmd     o_cmd,
    output pal_pkg::t_qstat   o_qstat
);
    import pal_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_cmd              r_mem [QDEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [PW:0]       r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.full  = (r_cnt == (PW+1)'(QDEPTH));
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_cmd         = r_mem[r_rp];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pal_back.sv =====
// ----------------------------------------------------------------------------
// pal_back
// Executes commands against the rule memory and the list table.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_back #(
    parameter int NUM_LISTS      = 16,
    parameter int RULES_PER_LIST = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  pal_pkg::t_cmd     i_cmd,
    input  pal_pkg::t_qstat   i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_stall,
    output logic [2:0]        o_status,
    output logic [4:0]        o_rule_count,
    output logic              o_permitted
);
    import pal_pkg::*;

    localparam int LW    = $clog2(NUM_LISTS);
    localparam int CW    = $clog2(RULES_PER_LIST + 1);
    localparam int DEPTH = NUM_LISTS * RULES_PER_LIST;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_LEN, S_SCAN, S_RESOLVE, S_SHRD, S_SHWR, S_FIN
    } t_state;

    // storage
    t_rule           r_rules [DEPTH];
    logic [CW-1:0]   r_lens  [NUM_LISTS];
    logic            r_def   [NUM_LISTS];
    t_rule           r_rd;
    logic [CW-1:0]   r_len_rd;

    t_state          r_state;
    t_cmd            r_cmd;
    logic [CW-1:0]   r_len;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_pos;
    logic            r_pv;
    logic            r_hit;
    logic            r_hperm;
    logic [2:0]      r_st;
    logic [CW-1:0]   r_cnt;
    logic            r_pm;

    logic [LW-1:0]   list;
    logic            def_now;
    logic [CW-1:0]   len_now;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_rule           wr_data;
    logic            hit_now;
    logic            out_free;
    logic [CW:0]     i_next;

    function automatic logic rule_eq(input t_rule a, input t_rule b);
        logic r;
        r = 1'b0;
        if (a.permit == b.permit) begin
            if (a.all && b.all) begin
                r = 1'b1;
            end else if (!a.all && !b.all) begin
                r = (a.len == b.len) && (((a.addr ^ b.addr) & len_mask(b.len)) == 32'd0)
                    && (a.has_wild == b.has_wild) && (a.wild == b.wild)
                    && (a.exact == b.exact) && (a.refine == b.refine);
            end
        end
        return r;
    endfunction

    function automatic logic rule_hit(input t_rule g, input t_rule t);
        logic [31:0] m;
        logic        ok;
        m  = len_mask(g.len) & ~(g.has_wild ? g.wild : 32'd0);
        ok = (g.refine && (t.len > g.len)) || ((!g.refine || g.exact) && (t.len == g.len));
        return g.all || (ok && (((t.addr ^ g.addr) & m) == 32'd0));
    endfunction

    function automatic logic [AW-1:0] ent(input logic [LW-1:0] l, input logic [CW:0] i);
        return AW'(int'(l) * RULES_PER_LIST + int'(i));
    endfunction

    assign list     = r_cmd.list[LW-1:0];
    assign def_now  = r_def[list];
    assign len_now  = def_now ? r_len_rd : '0;
    assign i_next   = {1'b0, r_i} + 1'b1;
    assign out_free = !o_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_qstat.empty;
    assign hit_now  = r_pv && ((r_cmd.func == FN_APPLY) ? rule_hit(r_rd, r_cmd.rule)
                                                        : rule_eq(r_rd, r_cmd.rule));

    // pick the rule read address
    always_comb begin
        rd_addr = ent(list, {1'b0, r_i});
        if (r_state == S_SHRD) begin
            rd_addr = ent(list, i_next);
        end
    end

    // single rule write port: append on add, move down on remove
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ent(list, {1'b0, r_len});
        wr_data = r_cmd.rule;
        if (r_state == S_RESOLVE && r_cmd.func == FN_ADD && !r_hit
            && ({1'b0, r_len} < (CW+1)'(RULES_PER_LIST))) begin
            wr_en = 1'b1;
        end else if (r_state == S_SHWR) begin
            wr_en   = 1'b1;
            wr_addr = ent(list, {1'b0, r_i});
            wr_data = r_rd;
        end
    end

    // rule memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rules[wr_addr] <= wr_data;
        end
        r_rd <= r_rules[rd_addr];
    end

    // length memory, read at the list of the command at the queue head
    always_ff @(posedge i_clk) begin
        r_len_rd <= r_lens[i_cmd.list[LW-1:0]];
        if (r_state == S_LEN && !r_cmd.bad && r_cmd.func == FN_DELETE && def_now) begin
            r_lens[list] <= '0;
        end else if (r_state == S_RESOLVE && r_cmd.func == FN_ADD && !r_hit
                     && ({1'b0, r_len} < (CW+1)'(RULES_PER_LIST))) begin
            r_lens[list] <= r_len + 1'b1;
        end else if (r_state == S_SHRD && !(i_next < {1'b0, r_len})) begin
            r_lens[list] <= r_len - 1'b1;
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_pv    <= 1'b0;
            for (int k = 0; k < NUM_LISTS; k++) begin
                r_def[k] <= 1'b0;
            end
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_len <= len_now;
                    r_i   <= '0;
                    r_pv  <= 1'b0;
                    r_hit <= 1'b0;
                    r_st  <= ST_OK;
                    r_cnt <= '0;
                    r_pm  <= 1'b0;
                    r_state <= S_FIN;
                    if (r_cmd.bad) begin
                        r_st <= ST_BADLIST;
                    end else if (r_cmd.func == FN_APPLY && r_cmd.list == 8'd0) begin
                        r_pm <= 1'b1;
                    end else if (r_cmd.func != FN_ADD && !def_now) begin
                        r_st <= ST_UNDEF;
                    end else if (r_cmd.func == FN_DELETE) begin
                        r_def[list] <= 1'b0;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit_now) begin
                        r_hit   <= 1'b1;
                        r_hperm <= r_rd.permit;
                        r_pv    <= 1'b0;
                        r_state <= S_RESOLVE;
                    end else if (r_i < r_len) begin
                        r_pv  <= 1'b1;
                        r_pos <= r_i;
                        r_i   <= r_i + 1'b1;
                    end else begin
                        r_pv    <= 1'b0;
                        r_state <= S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    r_cnt   <= r_len;
                    r_state <= S_FIN;
                    case (r_cmd.func)
                        FN_APPLY: begin
                            r_pm <= r_hit && r_hperm;
                            r_cnt <= '0;
                        end
                        FN_ADD: begin
                            if (r_hit) begin
                                r_st <= ST_DUP;
                            end else if ({1'b0, r_len} >= (CW+1)'(RULES_PER_LIST)) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_cnt       <= r_len + 1'b1;
                                r_def[list] <= 1'b1;
                            end
                        end
                        default: begin
                            if (!r_hit) begin
                                r_st <= ST_NORULE;
                            end else begin
                                r_i     <= r_pos;
                                r_state <= S_SHRD;
                            end
                        end
                    endcase
                end
                S_SHRD: begin
                    if (i_next < {1'b0, r_len}) begin
                        r_state <= S_SHWR;
                    end else begin
                        r_cnt   <= r_len - 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_SHWR: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SHRD;
                end
                S_FIN: begin
                    if (out_free) begin
                        o_valid      <= 1'b1;
                        o_status     <= r_st;
                        o_rule_count <= 5'(r_cnt);
                        o_permitted  <= r_pm;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_prefix_access_list_engine.sv =====
// ----------------------------------------------------------------------------
// tb_prefix_access_list_engine
// Self-checking bench: a behavioral copy of the access lists predicts status,
// rule count and permit result of each item. Directed tests cover bad lists,
// list zero, duplicates, full lists, removes and match rules. Random
// tests run rule-building sequences under several idle patterns and a long
// output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_prefix_access_list_engine;
    import pal_pkg::*;

    localparam int NLISTS   = 16;
    localparam int NRULES   = 16;
    localparam int WDOG_MAX = 20000;

    typedef struct {
        t_func       func;
        logic [7:0]  list;
        logic        permit;
        logic        all;
        logic [5:0]  len;
        logic [31:0] addr;
        logic        has_wild;
        logic [31:0] wild;
        logic        exact;
        logic        refine;
    } t_item;

    typedef struct {
        logic [2:0] status;
        logic [4:0] count;
        logic       permitted;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = '0;
    logic [7:0]  i_list_num = '0;
    logic        i_permit = 1'b0;
    logic        i_match_all = 1'b0;
    logic [5:0]  i_prefix_len = '0;
    logic [31:0] i_prefix_addr = '0;
    logic        i_has_wildcard = 1'b0;
    logic [31:0] i_wildcard_mask = '0;
    logic        i_exact_flag = 1'b0;
    logic        i_refine_flag = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [4:0]  o_rule_count;
    logic        o_permitted;

    // behavioral copy of the lists (length already clamped in stored rules)
    t_item    acl_rules[NLISTS][NRULES];
    int       acl_len[NLISTS];
    bit       acl_defined[NLISTS];
    t_outcome pending_outcomes[$];

    int  err_count  = 0;
    int  idle_send  = 0;
    int  idle_recv  = 0;
    bit  hold_recv  = 1'b0;
    int  idle_cnt   = 0;

    prefix_access_list_engine #(.NUM_LISTS(NLISTS), .RULES_PER_LIST(NRULES)) u_top (.*);

    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        if (len == 0) return 32'h0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic bit rules_equal(input t_item a, input t_item b);
        if (a.permit != b.permit) return 1'b0;
        if (a.all && b.all) return 1'b1;
        if (a.all || b.all) return 1'b0;
        if (a.len != b.len) return 1'b0;
        if (((a.addr ^ b.addr) & prefix_mask(b.len)) != 0) return 1'b0;
        if (a.has_wild != b.has_wild) return 1'b0;
        if (a.has_wild && a.wild != b.wild) return 1'b0;
        return a.exact == b.exact && a.refine == b.refine;
    endfunction

    function automatic int find_equal(input int l, input t_item r);
        for (int i = 0; i < acl_len[l]; i++)
            if (rules_equal(acl_rules[l][i], r)) return i;
        return -1;
    endfunction

    // -1 no match, else the rule action
    function automatic int match_rule(input t_item g, input logic [5:0] plen,
                                      input logic [31:0] addr);
        logic [31:0] m;
        if (g.all) return g.permit;
        if (!((g.refine && plen > g.len) || ((!g.refine || g.exact) && plen == g.len)))
            return -1;
        m = prefix_mask(g.len);
        if (g.has_wild) m &= ~g.wild;
        return (((addr ^ g.addr) & m) == 0) ? g.permit : -1;
    endfunction

    // update the lists and work out the result of one item
    function automatic t_outcome predict_outcome(input t_item it);
        t_outcome o;
        int l, pos, v;
        o = '{ST_OK, 5'd0, 1'b0};
        l = it.list;
        if (it.len > 6'd32) it.len = 6'd32;
        if (!it.has_wild) it.wild = '0;
        if (l >= NLISTS) begin
            o.status = ST_BADLIST;
        end else begin
            case (it.func)
                FN_ADD: begin
                    if (find_equal(l, it) >= 0) begin
                        o.status = ST_DUP;
                    end else if (acl_len[l] >= NRULES) begin
                        o.status = ST_FULL;
                    end else begin
                        acl_rules[l][acl_len[l]] = it;
                        acl_len[l]++;
                        acl_defined[l] = 1'b1;
                    end
                    o.count = 5'(acl_len[l]);
                end
                FN_REMOVE: begin
                    if (!acl_defined[l]) begin
                        o.status = ST_UNDEF;
                    end else begin
                        pos = find_equal(l, it);
                        if (pos < 0) begin
                            o.status = ST_NORULE;
                        end else begin
                            for (int i = pos; i + 1 < acl_len[l]; i++)
                                acl_rules[l][i] = acl_rules[l][i + 1];
                            acl_len[l]--;
                        end
                        o.count = 5'(acl_len[l]);
                    end
                end
                FN_DELETE: begin
                    if (!acl_defined[l]) begin
                        o.status = ST_UNDEF;
                    end else begin
                        acl_defined[l] = 1'b0;
                        acl_len[l] = 0;
                    end
                end
                default: begin
                    if (l == 0) begin
                        o.permitted = 1'b1;
                    end else if (!acl_defined[l]) begin
                        o.status = ST_UNDEF;
                    end else begin
                        for (int i = 0; i < acl_len[l]; i++) begin
                            v = match_rule(acl_rules[l][i], it.len, it.addr);
                            if (v >= 0) begin
                                o.permitted = v[0];
                                break;
                            end
                        end
                    end
                end
            endcase
        end
        return o;
    endfunction

    function automatic t_item make_item(input t_func f, input int l);
        t_item it;
        it.func = f;
        it.list = 8'(l);
        it.permit = 1'($urandom_range(1, 0));
        it.all = ($urandom_range(7, 0) == 0);
        it.len = ($urandom_range(15, 0) == 0) ? 6'($urandom_range(63, 33))
                                              : 6'($urandom_range(32, 0));
        it.addr = $urandom;
        it.has_wild = ($urandom_range(3, 0) == 0);
        it.wild = $urandom & $urandom;
        it.exact = 1'($urandom_range(1, 0));
        it.refine = 1'($urandom_range(1, 0));
        return it;
    endfunction

    // offer one item after random gaps, record its expected result on accept
    task automatic send_item(input t_item it);
        while (idle_send > 0 && $urandom_range(99, 0) < idle_send) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= it.func;
        i_list_num <= it.list;
        i_permit <= it.permit;
        i_match_all <= it.all;
        i_prefix_len <= it.len;
        i_prefix_addr <= it.addr;
        i_has_wildcard <= it.has_wild;
        i_wildcard_mask <= it.wild;
        i_exact_flag <= it.exact;
        i_refine_flag <= it.refine;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_outcomes.push_back(predict_outcome(it));
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // drive output stall at each falling edge
    always @(negedge i_clk) begin
        i_stall <= hold_recv || (idle_recv > 0 && $urandom_range(99, 0) < idle_recv);
    end

    // check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected results", 1, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_rule_count !== want.count)
                    report_mismatch("rule_count", o_rule_count, want.count);
                if (o_permitted !== want.permitted)
                    report_mismatch("permitted", o_permitted, want.permitted);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_bad_and_zero();
        t_item it;
        it = make_item(FN_APPLY, 0);
        send_item(it);
        it = make_item(FN_APPLY, 255); send_item(it);
        it = make_item(FN_ADD, 16);    send_item(it);
        it = make_item(FN_REMOVE, 3);  send_item(it);
        it = make_item(FN_DELETE, 3);  send_item(it);
        it = make_item(FN_APPLY, 3);   send_item(it);
    endtask

    task automatic test_rules();
        t_item it, r;
        // prefix rule and its duplicate, then applies at longer, equal and shorter lengths
        r = make_item(FN_ADD, 1);
        r.all = 1'b0; r.len = 6'd16; r.addr = 32'h0A0B_FFFF; r.has_wild = 1'b0;
        r.exact = 1'b0; r.refine = 1'b1; r.permit = 1'b1;
        send_item(r);
        send_item(r);
        it = r; it.func = FN_APPLY; it.len = 6'd24; send_item(it);
        it.len = 6'd16; send_item(it);
        it.len = 6'd8;  send_item(it);
        // wildcard rule, long length, match-all deny
        r.refine = 1'b0; r.exact = 1'b1; r.has_wild = 1'b1; r.wild = 32'hFFFF_FFFF;
        r.len = 6'd40; r.permit = 1'b0; send_item(r);
        it = r; it.func = FN_APPLY; it.addr = 32'h0; it.len = 6'd32; send_item(it);
        r.all = 1'b1; r.permit = 1'b0; send_item(r);
        it.len = 6'd0; send_item(it);
        it = r; it.func = FN_REMOVE; it.addr = 32'h1234_5678; send_item(it);
        send_item(it);
        // fill list 2 to the top, overflow, then empty it via delete
        for (int i = 0; i < NRULES + 1; i++) begin
            r = make_item(FN_ADD, 2); r.all = 1'b0; r.len = 6'd32; r.addr = 32'(i);
            send_item(r);
        end
        it = make_item(FN_DELETE, 2); send_item(it);
        it = make_item(FN_APPLY, 2); send_item(it);
    endtask

    // mostly valid-list sequences with reused rules so removes and hits occur
    task automatic test_random(input int n);
        t_item recent[$];
        t_item it;
        int    l;
        for (int k = 0; k < n; k++) begin
            l = ($urandom_range(19, 0) == 0) ? $urandom_range(255, NLISTS)
                                             : $urandom_range(5, 0);
            it = make_item(t_func'($urandom_range(3, 0)), l);
            if ($urandom_range(9, 0) < 4 && $urandom_range(4, 0) != 0)
                it.func = FN_ADD;
            if ($urandom_range(29, 0) == 0) it.func = FN_DELETE;
            else if (it.func == FN_DELETE) it.func = FN_APPLY;
            if (recent.size() > 0 && $urandom_range(1, 0)) begin
                t_item p;
                p = recent[$urandom_range(recent.size() - 1, 0)];
                p.func = it.func;
                p.list = it.list;
                if (it.func == FN_APPLY && $urandom_range(1, 0))
                    p.len = 6'(p.len + $urandom_range(3, 0));
                it = p;
            end
            if (it.func == FN_ADD) begin
                recent.push_back(it);
                if (recent.size() > 24) void'(recent.pop_front());
            end
            send_item(it);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_recv = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            test_random(12);
        join
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_outcomes.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_bad_and_zero();
        test_rules();
        idle_send = 17; idle_recv = 45;
        test_random(500);
        test_backpressure();
        idle_send = 45; idle_recv = 17;
        test_random(500);
        idle_send = 0; idle_recv = 0;
        test_random(500);
        drain();
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
